// ===== hw/rtl/bdqs_pkg.sv =====
// ---------------------------------------------------------------------------
// bdqs_pkg
// Shared request and status codes, field widths and the control/status
// bundles passed between the deque controller and its datapath.
// ---------------------------------------------------------------------------
package bdqs_pkg;

    localparam int REQ_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 5;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [INDEX_W-1:0] FOUND_NONE = 5'sb11111;

    typedef struct packed {
        logic take;         // input transfer: update pointers, start search
        logic scan;         // advance the search pipeline
        logic src_scan;     // result comes from the search, not the request
        logic load_out;     // new result into output register
        logic load_hold;    // new result into hold register
        logic hold_to_out;  // hold register into output register
    } bdqs_cmd_t;

    typedef struct packed {
        logic is_search;
        logic empty;
        logic full;
        logic hit;
        logic miss;
    } bdqs_stat_t;

endpackage

// ===== hw/rtl/bdqs_ram.sv =====
// ---------------------------------------------------------------------------
// bdqs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bdqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/bdqs_ctrl.sv =====
// ---------------------------------------------------------------------------
// bdqs_ctrl
// Request sequencer: accepts requests, runs searches, and steers results
// into the output register or a one-deep hold register.
// ---------------------------------------------------------------------------
module bdqs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  bdqs_pkg::bdqs_stat_t stat,
    output bdqs_pkg::bdqs_cmd_t  cmd
);
    import bdqs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take = 1'b1;
                    if (stat.is_search && !stat.empty) begin
                        state_next = S_SCAN;
                    end else if (out_free) begin
                        cmd.load_out = 1'b1;
                        m_valid_next = 1'b1;
                    end else begin
                        cmd.load_hold = 1'b1;
                        state_next    = S_HOLD;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan     = 1'b1;
                cmd.src_scan = 1'b1;
                if (stat.hit || stat.miss) begin
                    if (out_free) begin
                        cmd.load_out = 1'b1;
                        m_valid_next = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        cmd.load_hold = 1'b1;
                        state_next    = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    cmd.hold_to_out = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/bdqs_dpath.sv =====
// ---------------------------------------------------------------------------
// bdqs_dpath
// Ring pointers, entry RAM, pipelined search compare and result registers.
// ---------------------------------------------------------------------------
module bdqs_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [bdqs_pkg::REQ_W-1:0]           s_req_type,
    input  logic signed [bdqs_pkg::DATA_W-1:0]   s_item_value,
    input  logic signed [bdqs_pkg::DATA_W-1:0]   s_search_key,
    output logic [bdqs_pkg::STATUS_W-1:0]        m_status,
    output logic signed [bdqs_pkg::INDEX_W-1:0]  m_found_index,
    input  bdqs_pkg::bdqs_cmd_t                  cmd,
    output bdqs_pkg::bdqs_stat_t                 stat
);
    import bdqs_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W:0]   DEPTH_W  = (CNT_W + 1)'(DEPTH);

    logic [PTR_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  scan_addr_reg, scan_addr_next;
    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic [PTR_W-1:0]  cmp_idx_reg;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [DATA_W-1:0] key_reg;
    logic [STATUS_W-1:0]       out_status_reg, hold_status_reg;
    logic signed [INDEX_W-1:0] out_found_reg, hold_found_reg;

    logic [PTR_W-1:0]  front_dec, front_inc, back_addr;
    logic [CNT_W:0]    back_sum;
    logic              full, empty, issue_go;
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] rdata;
    logic              hit, miss;
    logic [STATUS_W-1:0]       imm_status, new_status;
    logic signed [INDEX_W-1:0] new_found;

    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? LAST_PTR : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_PTR) ? '0 : front_reg + 1'b1;
    assign back_sum  = (CNT_W + 1)'(front_reg) + (CNT_W + 1)'(count_reg);
    assign back_addr = (back_sum >= DEPTH_W) ? PTR_W'(back_sum - DEPTH_W)
                                             : PTR_W'(back_sum);

    always_comb begin
        we         = 1'b0;
        waddr      = back_addr;
        front_next = front_reg;
        count_next = count_reg;
        imm_status = ST_DONE;
        case (s_req_type)
            REQ_PUSH_FRONT: begin
                waddr = front_dec;
                if (full) begin
                    imm_status = ST_FULL;
                end else begin
                    we         = cmd.take;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                if (full) begin
                    imm_status = ST_FULL;
                end else begin
                    we         = cmd.take;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (empty) begin
                    imm_status = ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                    if (s_req_type == REQ_POP_FRONT) begin
                        front_next = front_inc;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    bdqs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (s_item_value),
        .raddr (scan_addr_reg),
        .rdata (rdata)
    );

    // search: one read issued per cycle, compared in the next cycle
    assign issue_go       = (issue_cnt_reg < count_reg);
    assign scan_addr_next = (scan_addr_reg == LAST_PTR) ? '0 : scan_addr_reg + 1'b1;
    assign issue_cnt_next = issue_go ? issue_cnt_reg + 1'b1 : issue_cnt_reg;
    assign cmp_valid_next = cmd.scan && issue_go;
    assign hit  = cmp_valid_reg && (rdata == key_reg);
    assign miss = cmp_valid_reg && !hit && (CNT_W'(cmp_idx_reg) + 1'b1 == count_reg);

    assign stat.is_search = (s_req_type == REQ_SEARCH);
    assign stat.empty     = empty;
    assign stat.full      = full;
    assign stat.hit       = hit;
    assign stat.miss      = miss;

    assign new_status = cmd.src_scan ? ST_DONE : imm_status;
    assign new_found  = (cmd.src_scan && hit) ? INDEX_W'(cmp_idx_reg) : FOUND_NONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            if (cmd.take) begin
                front_reg     <= front_next;
                count_reg     <= count_next;
                cmp_valid_reg <= 1'b0;
            end else begin
                cmp_valid_reg <= cmp_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            key_reg       <= s_search_key;
            scan_addr_reg <= front_reg;
            issue_cnt_reg <= '0;
        end else if (cmd.scan && issue_go) begin
            scan_addr_reg <= scan_addr_next;
            issue_cnt_reg <= issue_cnt_next;
            cmp_idx_reg   <= PTR_W'(issue_cnt_reg);
        end
        if (cmd.load_out) begin
            out_status_reg <= new_status;
            out_found_reg  <= new_found;
        end else if (cmd.hold_to_out) begin
            out_status_reg <= hold_status_reg;
            out_found_reg  <= hold_found_reg;
        end
        if (cmd.load_hold) begin
            hold_status_reg <= new_status;
            hold_found_reg  <= new_found;
        end
    end

    assign m_status      = out_status_reg;
    assign m_found_index = out_found_reg;

endmodule

// ===== hw/rtl/bounded_deque_with_search_unit.sv =====
// ---------------------------------------------------------------------------
// bounded_deque_with_search_unit
// Bounded double-ended queue of signed 32-bit values with linear search.
//
// s_* channel: one request per transfer (push front/back, pop front/back,
// search). m_* channel: one result per request, status and found index.
// Push, pop, unused codes and empty-queue searches finish in the transfer
// cycle; the result is in the output or hold register on the next cycle,
// and if the output is free the next one is taken at once (one per cycle).
// A search on a non-empty queue reads the entry RAM once per cycle from the
// front, compare in the cycle after the read. The result is loaded at the
// first match, with its position from the front, or once the last entry
// has been compared with no match; s_ready stays low until then, so the
// next request is not taken before the result is loaded.
// Results go to the output register, or to a one-deep hold register when
// the output is still occupied; a stalled receiver then blocks new requests
// only once the hold register is full.
// Reset empties the queue (front and count cleared); RAM contents are left
// as they are, entries outside the held range are never compared.
// ---------------------------------------------------------------------------
module bounded_deque_with_search_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [bdqs_pkg::REQ_W-1:0]           s_req_type,
    input  logic signed [bdqs_pkg::DATA_W-1:0]   s_item_value,
    input  logic signed [bdqs_pkg::DATA_W-1:0]   s_search_key,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [bdqs_pkg::STATUS_W-1:0]        m_status,
    output logic signed [bdqs_pkg::INDEX_W-1:0]  m_found_index
);
    import bdqs_pkg::*;

    bdqs_cmd_t  cmd;
    bdqs_stat_t stat;

    bdqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bdqs_dpath #(
        .DEPTH(DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_req_type    (s_req_type),
        .s_item_value  (s_item_value),
        .s_search_key  (s_search_key),
        .m_status      (m_status),
        .m_found_index (m_found_index),
        .cmd           (cmd),
        .stat          (stat)
    );

    a_search_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == REQ_SEARCH && !stat.empty) |=> !s_ready)
        else $error("request taken while a search is running");

    a_result_route: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_out, cmd.load_hold, cmd.hold_to_out}))
        else $error("result routed to more than one register");

    a_count_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.empty && stat.full))
        else $error("queue seen both empty and full");

    a_done_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out || cmd.hold_to_out) |=> m_valid)
        else $error("result loaded without output valid");

endmodule

// ===== test/bounded_deque_with_search_unit_tb.sv =====
// ---------------------------------------------------------------------------
// bounded_deque_with_search_unit_tb
// Self-checking testbench for the bounded deque with linear search. A driver
// feeds push, pop, search and unused-code requests from a pending queue, a
// monitor compares every result transfer against a cycle-free deque model
// kept in the testbench, under several sender idle and receiver stall mixes.
// ---------------------------------------------------------------------------
module bounded_deque_with_search_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bdqs_pkg::*;

    localparam int RING_DEPTH = 16;

    typedef struct {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] search_key;
    } deque_req_t;

    typedef struct {
        logic [STATUS_W-1:0]        status;
        logic signed [INDEX_W-1:0]  found_index;
    } deque_reply_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [REQ_W-1:0]            s_req_type = REQ_PUSH_FRONT;
    logic signed [DATA_W-1:0]    s_item_value = '0;
    logic signed [DATA_W-1:0]    s_search_key = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [STATUS_W-1:0]         m_status;
    logic signed [INDEX_W-1:0]   m_found_index;

    // deque model state
    logic signed [DATA_W-1:0]    ring_model [RING_DEPTH];
    logic [3:0]                  front_idx = '0;
    int                          held = 0;

    deque_req_t                  request_q[$];
    deque_reply_t                awaited_replies[$];
    deque_req_t                  cur_req;
    deque_reply_t                got_reply;
    int                          sender_idle_pct = 0;
    int                          recv_stall_pct = 0;
    int                          errors = 0;

    bounded_deque_with_search_unit #(
        .DEPTH(RING_DEPTH)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_item_value (s_item_value),
        .s_search_key (s_search_key),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found_index(m_found_index)
    );

    always #5 aclk = ~aclk;

    function automatic deque_reply_t apply_request(deque_req_t r);
        deque_reply_t rep;
        logic [3:0]   pos;
        rep.status      = ST_DONE;
        rep.found_index = FOUND_NONE;
        case (r.req_type)
            REQ_PUSH_FRONT: begin
                if (held >= RING_DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    front_idx = front_idx - 4'd1;
                    ring_model[front_idx] = r.item_value;
                    held++;
                end
            end
            REQ_PUSH_BACK: begin
                if (held >= RING_DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    pos = front_idx + 4'(held);
                    ring_model[pos] = r.item_value;
                    held++;
                end
            end
            REQ_POP_FRONT: begin
                if (held == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    front_idx = front_idx + 4'd1;
                    held--;
                end
            end
            REQ_POP_BACK: begin
                if (held == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    held--;
                end
            end
            REQ_SEARCH: begin
                for (int i = held - 1; i >= 0; i--) begin
                    pos = front_idx + 4'(i);
                    if (ring_model[pos] == r.search_key) begin
                        rep.found_index = INDEX_W'(i);
                    end
                end
            end
            default: begin
            end
        endcase
        return rep;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_replies = {awaited_replies, apply_request(cur_req)};
            end
            if (s_valid && !s_ready) begin
                // hold the request until transfer
            end else if (request_q.size() != 0 &&
                         $urandom_range(0, 99) >= sender_idle_pct) begin
                cur_req = request_q[0];
                request_q.delete(0);
                s_valid      <= 1'b1;
                s_req_type   <= cur_req.req_type;
                s_item_value <= cur_req.item_value;
                s_search_key <= cur_req.search_key;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    if (errors < 10) begin
                        $display("ERROR %0t: unexpected result status=%0d index=%0d",
                                 $realtime, m_status, m_found_index);
                    end
                    errors++;
                end else begin
                    got_reply = awaited_replies[0];
                    awaited_replies.delete(0);
                    if (m_status !== got_reply.status ||
                        m_found_index !== got_reply.found_index) begin
                        if (errors < 10) begin
                            $display("ERROR %0t: status exp %0d got %0d, index exp %0d got %0d",
                                     $realtime, got_reply.status, m_status,
                                     got_reply.found_index, m_found_index);
                        end
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic add_req(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] value,
                           input logic [DATA_W-1:0] key);
        deque_req_t r;
        r.req_type   = kind;
        r.item_value = value;
        r.search_key = key;
        request_q = {request_q, r};
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
            return DATA_W'($urandom_range(0, 11)) - 32'd6;
        end else if (sel == 6) begin
            return 32'h7FFF_FFFF;
        end else if (sel == 7) begin
            return 32'h8000_0000;
        end
        return $urandom;
    endfunction

    task automatic add_traffic(input int n);
        int produced;
        int burst;
        int mode;
        produced = 0;
        while (produced < n) begin
            mode = $urandom_range(0, 9);
            if (mode <= 2) begin
                burst = $urandom_range(1, 18);
                repeat (burst) begin
                    add_req($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                            pick_value(), $urandom);
                end
            end else if (mode <= 4) begin
                burst = $urandom_range(1, 18);
                repeat (burst) begin
                    add_req($urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT,
                            $urandom, $urandom);
                end
            end else if (mode <= 7) begin
                burst = $urandom_range(1, 6);
                repeat (burst) begin
                    add_req(REQ_SEARCH, $urandom, pick_value());
                end
            end else if (mode == 8) begin
                burst = $urandom_range(1, 8);
                repeat (burst) begin
                    add_req(REQ_W'($urandom_range(0, 4)), pick_value(), pick_value());
                end
            end else begin
                burst = 1;
                add_req(REQ_W'($urandom_range(0, 7)), $urandom, $urandom);
            end
            produced += burst;
        end
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || s_valid || awaited_replies.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty queue, single entry, extremes, unused codes
        add_req(REQ_POP_FRONT, 32'h1111_1111, 32'h0);
        add_req(REQ_POP_BACK, 32'h0, 32'h0);
        add_req(REQ_SEARCH, 32'h0, 32'h0);
        add_req(REQ_PUSH_BACK, 32'd5, 32'h0);
        add_req(REQ_POP_BACK, 32'h0, 32'h0);
        add_req(REQ_POP_FRONT, 32'h0, 32'h0);
        add_req(REQ_PUSH_FRONT, 32'h7FFF_FFFF, 32'h0);
        add_req(REQ_PUSH_BACK, 32'h8000_0000, 32'h0);
        add_req(REQ_PUSH_FRONT, 32'h0, 32'hFFFF_FFFF);
        add_req(REQ_PUSH_BACK, 32'hFFFF_FFFF, 32'h0);
        add_req(REQ_SEARCH, 32'h0, 32'h8000_0000);
        add_req(REQ_SEARCH, 32'h0, 32'hFFFF_FFFF);
        add_req(REQ_SEARCH, 32'hFFFF_FFFF, 32'h0);
        add_req(REQ_SEARCH, 32'h0, 32'h7FFF_FFFF);
        add_req(REQ_SEARCH, 32'h0, 32'h0000_3039);
        add_req(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(3'd6, 32'h0, 32'h0);
        add_req(3'd7, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        add_req(REQ_POP_FRONT, 32'h0, 32'h0);
        add_req(REQ_POP_BACK, 32'h0, 32'h0);
        add_req(REQ_POP_FRONT, 32'h0, 32'h0);
        add_req(REQ_POP_BACK, 32'h0, 32'h0);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            add_traffic(270);
            wait_drained();
        end

        repeat (50) @(posedge aclk);
        errors += awaited_replies.size();
        if (errors == 0) begin
            $display("bounded_deque_with_search_unit regression: pass");
        end else begin
            $display("bounded_deque_with_search_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("bounded_deque_with_search_unit regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bdqs_pkg.sv
hw/rtl/bdqs_ram.sv
hw/rtl/bdqs_ctrl.sv
hw/rtl/bdqs_dpath.sv
hw/rtl/bounded_deque_with_search_unit.sv
test/bounded_deque_with_search_unit_tb.sv
